FILE: rtl/core/fssr_pkg.sv
// Shared widths, constants and sideband types of the sample weight unit.
package fssr_pkg;

  localparam int COORD_W    = 32;
  localparam int FP_W       = 31;
  localparam int NRM_W      = 16;
  localparam int TAG_W      = 32;
  localparam int MAG_W      = COORD_W + 1;
  localparam int RATIO_BITS = 28;
  localparam int QUOT_W     = RATIO_BITS + 1;
  localparam int ROOT_W     = RATIO_BITS;
  localparam int VSQ_W      = 2 * RATIO_BITS;
  localparam int NRM_SHIFT  = 14;

  typedef struct packed {
    logic [2:0]              neg;
    logic                    bad;
    logic signed [NRM_W-1:0] nx;
    logic signed [NRM_W-1:0] ny;
    logic signed [NRM_W-1:0] nz;
    logic [TAG_W-1:0]        tag;
  } div_side_t;

  typedef struct packed {
    logic                  bad;
    logic                  uneg;
    logic [RATIO_BITS-1:0] umag;
    logic [RATIO_BITS-1:0] usqh;
    logic [RATIO_BITS-1:0] vsqh;
    logic [TAG_W-1:0]      tag;
  } sqrt_side_t;

endpackage

FILE: rtl/core/fssr_div.sv
// Three-lane pipelined restoring divider, one quotient bit per stage.
module fssr_div import fssr_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_vld_i,
  input  logic [2:0][MAG_W-1:0]        mag_i,
  input  logic [MAG_W-1:0]             den_i,
  input  div_side_t                    side_i,
  output logic                         out_vld_o,
  output logic [2:0][QUOT_W-1:0]       quo_o,
  output div_side_t                    side_o
);

  logic [QUOT_W-1:0]           vld_q;
  div_side_t                   side_q [QUOT_W];
  logic [MAG_W-1:0]            den_q  [QUOT_W];
  logic [2:0][MAG_W-1:0]       rem_q  [QUOT_W];
  logic [2:0][QUOT_W-1:0]      quo_q  [QUOT_W];

  for (genvar k = 0; k < QUOT_W; k++) begin : g_stg
    logic                   vld_in;
    div_side_t              side_in;
    logic [MAG_W-1:0]       den_in;
    logic [2:0][MAG_W-1:0]  rem_in;
    logic [2:0][QUOT_W-1:0] quo_in;
    logic [2:0]             bit_in;
    logic [2:0][MAG_W-1:0]  rem_d;
    logic [2:0][QUOT_W-1:0] quo_d;

    if (k == 0) begin : g_first
      always_comb begin
        vld_in  = in_vld_i;
        side_in = side_i;
        den_in  = den_i;
        quo_in  = '0;
        for (int l = 0; l < 3; l++) begin
          rem_in[l] = {1'b0, mag_i[l][MAG_W-1:1]};
          bit_in[l] = mag_i[l][0];
        end
      end
    end else begin : g_next
      always_comb begin
        vld_in  = vld_q[k-1];
        side_in = side_q[k-1];
        den_in  = den_q[k-1];
        rem_in  = rem_q[k-1];
        quo_in  = quo_q[k-1];
        bit_in  = '0;
      end
    end

    always_comb begin
      logic [MAG_W:0] trial;
      logic           ge;
      for (int l = 0; l < 3; l++) begin
        trial     = {rem_in[l], bit_in[l]};
        ge        = trial >= {1'b0, den_in};
        rem_d[l]  = ge ? MAG_W'(trial - {1'b0, den_in}) : trial[MAG_W-1:0];
        quo_d[l]  = {quo_in[l][QUOT_W-2:0], ge};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      side_q[k] <= side_in;
      den_q[k]  <= den_in;
      rem_q[k]  <= rem_d;
      quo_q[k]  <= quo_d;
    end
  end

  assign out_vld_o = vld_q[QUOT_W-1];
  assign quo_o     = quo_q[QUOT_W-1];
  assign side_o    = side_q[QUOT_W-1];

endmodule

FILE: rtl/core/fssr_sqrt.sv
// Pipelined floor square root, one root bit per stage.
module fssr_sqrt import fssr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_vld_i,
  input  logic [VSQ_W-1:0]  rad_i,
  input  sqrt_side_t        side_i,
  output logic              out_vld_o,
  output logic [ROOT_W-1:0] root_o,
  output sqrt_side_t        side_o
);

  localparam int REM_W = ROOT_W + 2;

  logic [ROOT_W-1:0] vld_q;
  sqrt_side_t        side_q [ROOT_W];
  logic [VSQ_W-1:0]  rad_q  [ROOT_W];
  logic [REM_W-1:0]  rem_q  [ROOT_W];
  logic [ROOT_W-1:0] root_q [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stg
    logic              vld_in;
    sqrt_side_t        side_in;
    logic [VSQ_W-1:0]  rad_in;
    logic [REM_W-1:0]  rem_in;
    logic [ROOT_W-1:0] root_in;
    logic [REM_W-1:0]  rem_d;
    logic [ROOT_W-1:0] root_d;

    if (k == 0) begin : g_first
      always_comb begin
        vld_in  = in_vld_i;
        side_in = side_i;
        rad_in  = rad_i;
        rem_in  = '0;
        root_in = '0;
      end
    end else begin : g_next
      always_comb begin
        vld_in  = vld_q[k-1];
        side_in = side_q[k-1];
        rad_in  = rad_q[k-1];
        rem_in  = rem_q[k-1];
        root_in = root_q[k-1];
      end
    end

    always_comb begin
      logic [REM_W+1:0] cur;
      logic [REM_W+1:0] trial;
      logic             ge;
      cur    = {rem_in, rad_in[VSQ_W-1-2*k -: 2]};
      trial  = {2'b00, root_in, 2'b01};
      ge     = cur >= trial;
      rem_d  = ge ? REM_W'(cur - trial) : cur[REM_W-1:0];
      root_d = {root_in[ROOT_W-2:0], ge};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      side_q[k] <= side_in;
      rad_q[k]  <= rad_in;
      rem_q[k]  <= rem_d;
      root_q[k] <= root_d;
    end
  end

  assign out_vld_o = vld_q[ROOT_W-1];
  assign root_o    = root_q[ROOT_W-1];
  assign side_o    = side_q[ROOT_W-1];

endmodule

FILE: rtl/core/fssr_wgt.sv
// Falloff polynomials, final product, scaling and output registers.
module fssr_wgt import fssr_pkg::*; #(
  parameter int WEIGHT_FRAC_BITS = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_vld_i,
  input  logic [ROOT_W-1:0]         root_i,
  input  sqrt_side_t                side_i,
  output logic                      done_o,
  output logic [WEIGHT_FRAC_BITS:0] weight_o,
  output logic                      in_support_o,
  output logic [TAG_W-1:0]          tag_out_o
);

  localparam int SHIFT = 2 * RATIO_BITS - WEIGHT_FRAC_BITS;
  localparam int PW    = 2 * QUOT_W + 1;
  localparam logic [RATIO_BITS+1:0] THREE = (RATIO_BITS + 2)'(3) << RATIO_BITS;
  localparam logic [QUOT_W-1:0]     ONE   = QUOT_W'(1) << RATIO_BITS;

  logic [3:0]       vld_q;
  logic             bad_q [4];
  logic [TAG_W-1:0] tag_q [4];

  logic [PW-1:0] p1_t_d, p1_t_q, p1_a_d, p1_a_q;
  logic          p1_neg_q;
  logic [QUOT_W-1:0] p2_ax_d, p2_ax_q, p2_tg_d, p2_tg_q;
  logic [2*QUOT_W-1:0] p3_w_d, p3_w_q;
  logic [WEIGHT_FRAC_BITS:0] p4_w_d, p4_w_q;

  always_comb begin
    logic [QUOT_W-1:0]     w;
    logic [RATIO_BITS+1:0] ka;
    logic [RATIO_BITS+1:0] kt;
    w      = ONE - {1'b0, side_i.umag};
    ka     = THREE - {1'b0, side_i.umag, 1'b0};
    kt     = THREE - {1'b0, root_i, 1'b0};
    p1_t_d = PW'(side_i.vsqh) * PW'(kt);
    p1_a_d = side_i.uneg ? PW'(w) * PW'(w) : PW'(side_i.usqh) * PW'(ka);
  end

  always_comb begin
    logic [PW-1:0] ts;
    logic [PW-1:0] as;
    ts      = p1_t_q >> RATIO_BITS;
    as      = p1_a_q >> RATIO_BITS;
    p2_tg_d = (ts >= PW'(ONE)) ? '0 : QUOT_W'(PW'(ONE) - ts);
    if (p1_neg_q) begin
      p2_ax_d = as[QUOT_W-1:0];
    end else begin
      p2_ax_d = (as >= PW'(ONE)) ? '0 : QUOT_W'(PW'(ONE) - as);
    end
  end

  assign p3_w_d = (2*QUOT_W)'(p2_ax_q) * (2*QUOT_W)'(p2_tg_q);

  always_comb begin
    logic [2*QUOT_W-1:0] ws;
    ws = p3_w_q >> SHIFT;
    if (bad_q[2]) begin
      p4_w_d = '0;
    end else if (ws > (2*QUOT_W)'(1 << WEIGHT_FRAC_BITS)) begin
      p4_w_d = (WEIGHT_FRAC_BITS+1)'(1 << WEIGHT_FRAC_BITS);
    end else begin
      p4_w_d = ws[WEIGHT_FRAC_BITS:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[2:0], in_vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    bad_q[0] <= side_i.bad;
    tag_q[0] <= side_i.tag;
    for (int i = 1; i < 4; i++) begin
      bad_q[i] <= bad_q[i-1];
      tag_q[i] <= tag_q[i-1];
    end
    p1_t_q   <= p1_t_d;
    p1_a_q   <= p1_a_d;
    p1_neg_q <= side_i.uneg;
    p2_ax_q  <= p2_ax_d;
    p2_tg_q  <= p2_tg_d;
    p3_w_q   <= p3_w_d;
    p4_w_q   <= p4_w_d;
  end

  assign done_o       = vld_q[3];
  assign weight_o     = p4_w_q;
  assign in_support_o = ~bad_q[3];
  assign tag_out_o    = tag_q[3];

endmodule

FILE: rtl/core/fssr_sample_weight_unit.sv
// Throughput: one word per cycle; set by the bit-per-stage divider and square root.
// busy_o stays low: every stage advances each cycle and the receiver cannot stall.
// Reset clears only the pipeline valid bits; results appear only for accepted words.
module fssr_sample_weight_unit import fssr_pkg::*; #(
  parameter int WEIGHT_FRAC_BITS = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  output logic                      busy_o,
  input  logic signed [COORD_W-1:0] point_x_i,
  input  logic signed [COORD_W-1:0] point_y_i,
  input  logic signed [COORD_W-1:0] point_z_i,
  input  logic signed [COORD_W-1:0] center_x_i,
  input  logic signed [COORD_W-1:0] center_y_i,
  input  logic signed [COORD_W-1:0] center_z_i,
  input  logic signed [NRM_W-1:0]   normal_x_i,
  input  logic signed [NRM_W-1:0]   normal_y_i,
  input  logic signed [NRM_W-1:0]   normal_z_i,
  input  logic [FP_W-1:0]           footprint_i,
  input  logic [TAG_W-1:0]          sample_tag_i,
  output logic                      done_o,
  output logic [WEIGHT_FRAC_BITS:0] weight_o,
  output logic                      in_support_o,
  output logic [TAG_W-1:0]          tag_out_o
);

  localparam int PROD_W = NRM_W + QUOT_W + 1;
  localparam int SUM_W  = PROD_W + 2;
  localparam int SQ_W   = 2 * QUOT_W;
  localparam int SSQ_W  = SQ_W + 2;
  localparam int UF_W   = SUM_W - NRM_SHIFT;

  logic in_vld;

  // front end
  logic                    a1_vld_q, a2_vld_q;
  logic signed [MAG_W-1:0] a1_d_d [3];
  logic signed [MAG_W-1:0] a1_d_q [3];
  logic [MAG_W-1:0]        a1_rng_d, a1_rng_q, a2_rng_q;
  logic signed [NRM_W-1:0] a1_n_q [3];
  logic [TAG_W-1:0]        a1_tag_q;
  logic [2:0][MAG_W-1:0]   a2_mag_d, a2_mag_q;
  logic [2:0]              a2_neg_d, a2_far_d;
  div_side_t               a2_side_q;

  // divider
  logic                    dv_vld;
  logic [2:0][QUOT_W-1:0]  dv_quo;
  div_side_t               dv_side;

  // dot product and squared length
  logic                    m1_vld_q, m2_vld_q, m3_vld_q, m4_vld_q, m5_vld_q;
  logic signed [NRM_W-1:0] m1_nrm [3];
  logic signed [PROD_W-1:0] m1_p_d [3];
  logic signed [PROD_W-1:0] m1_p_q [3];
  logic [SQ_W-1:0]         m1_sq_d [3];
  logic [SQ_W-1:0]         m1_sq_q [3];
  logic [2:0]              m1_neg_q;
  logic                    m1_bad_q, m2_bad_q, m3_bad_q, m4_bad_q;
  logic [TAG_W-1:0]        m1_tag_q, m2_tag_q, m3_tag_q, m4_tag_q;
  logic signed [SUM_W-1:0] m2_s_d, m2_s_q;
  logic [SSQ_W-1:0]        m2_ssq_d, m2_ssq_q, m3_ssq_q, m4_ssq_q;
  logic [UF_W-1:0]         m3_uf_d;
  logic [RATIO_BITS-1:0]   m3_um_q, m4_um_q;
  logic                    m3_neg_d, m3_neg_q, m4_neg_q;
  logic                    m3_bad_d;
  logic [VSQ_W-1:0]        m4_usq_d, m4_usq_q;
  logic [SSQ_W-1:0]        m5_vsq_d;
  logic [VSQ_W-1:0]        m5_rad_q;
  sqrt_side_t              m5_side_d, m5_side_q;

  // square root
  logic                    sq_vld;
  logic [ROOT_W-1:0]       sq_root;
  sqrt_side_t              sq_side;

  assign busy_o = 1'b0;
  assign in_vld = start_i & ~busy_o;

  always_comb begin
    a1_d_d[0] = MAG_W'(point_x_i) - MAG_W'(center_x_i);
    a1_d_d[1] = MAG_W'(point_y_i) - MAG_W'(center_y_i);
    a1_d_d[2] = MAG_W'(point_z_i) - MAG_W'(center_z_i);
    a1_rng_d  = {2'b00, footprint_i} + {1'b0, footprint_i, 1'b0};
  end

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      a2_neg_d[l] = a1_d_q[l][MAG_W-1];
      a2_mag_d[l] = a2_neg_d[l] ? MAG_W'(-a1_d_q[l]) : MAG_W'(a1_d_q[l]);
      a2_far_d[l] = {1'b0, a2_mag_d[l]} >= {a1_rng_q, 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a1_vld_q <= 1'b0;
      a2_vld_q <= 1'b0;
      m1_vld_q <= 1'b0;
      m2_vld_q <= 1'b0;
      m3_vld_q <= 1'b0;
      m4_vld_q <= 1'b0;
      m5_vld_q <= 1'b0;
    end else begin
      a1_vld_q <= in_vld;
      a2_vld_q <= a1_vld_q;
      m1_vld_q <= dv_vld;
      m2_vld_q <= m1_vld_q;
      m3_vld_q <= m2_vld_q;
      m4_vld_q <= m3_vld_q;
      m5_vld_q <= m4_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a1_d_q     <= a1_d_d;
    a1_rng_q   <= a1_rng_d;
    a1_n_q[0]  <= normal_x_i;
    a1_n_q[1]  <= normal_y_i;
    a1_n_q[2]  <= normal_z_i;
    a1_tag_q   <= sample_tag_i;
    a2_mag_q   <= a2_mag_d;
    a2_rng_q   <= a1_rng_q;
    a2_side_q.neg <= a2_neg_d;
    a2_side_q.bad <= |a2_far_d;
    a2_side_q.nx  <= a1_n_q[0];
    a2_side_q.ny  <= a1_n_q[1];
    a2_side_q.nz  <= a1_n_q[2];
    a2_side_q.tag <= a1_tag_q;
  end

  fssr_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_vld_i  (a2_vld_q),
    .mag_i     (a2_mag_q),
    .den_i     (a2_rng_q),
    .side_i    (a2_side_q),
    .out_vld_o (dv_vld),
    .quo_o     (dv_quo),
    .side_o    (dv_side)
  );

  always_comb begin
    m1_nrm[0] = dv_side.nx;
    m1_nrm[1] = dv_side.ny;
    m1_nrm[2] = dv_side.nz;
    for (int l = 0; l < 3; l++) begin
      m1_p_d[l]  = m1_nrm[l] * $signed({1'b0, dv_quo[l]});
      m1_sq_d[l] = SQ_W'(dv_quo[l]) * SQ_W'(dv_quo[l]);
    end
  end

  always_comb begin
    logic signed [SUM_W-1:0] t;
    m2_s_d   = '0;
    m2_ssq_d = '0;
    for (int l = 0; l < 3; l++) begin
      t        = SUM_W'(m1_p_q[l]);
      m2_s_d   = m2_s_d + (m1_neg_q[l] ? -t : t);
      m2_ssq_d = m2_ssq_d + SSQ_W'(m1_sq_q[l]);
    end
  end

  always_comb begin
    logic [SUM_W-1:0] sabs;
    sabs     = m2_s_q[SUM_W-1] ? SUM_W'(-m2_s_q) : SUM_W'(m2_s_q);
    m3_uf_d  = UF_W'(sabs >> NRM_SHIFT);
    m3_bad_d = m2_bad_q | (|m3_uf_d[UF_W-1:RATIO_BITS]);
    m3_neg_d = m2_s_q[SUM_W-1] & (m3_uf_d != '0);
  end

  assign m4_usq_d = VSQ_W'(m3_um_q) * VSQ_W'(m3_um_q);

  always_comb begin
    m5_vsq_d       = (m4_ssq_q > SSQ_W'(m4_usq_q)) ? m4_ssq_q - SSQ_W'(m4_usq_q) : '0;
    m5_side_d.bad  = m4_bad_q | (|m5_vsq_d[SSQ_W-1:VSQ_W]);
    m5_side_d.uneg = m4_neg_q;
    m5_side_d.umag = m4_um_q;
    m5_side_d.usqh = m4_usq_q[VSQ_W-1:RATIO_BITS];
    m5_side_d.vsqh = m5_vsq_d[VSQ_W-1:RATIO_BITS];
    m5_side_d.tag  = m4_tag_q;
  end

  always_ff @(posedge clk_i) begin
    m1_p_q    <= m1_p_d;
    m1_sq_q   <= m1_sq_d;
    m1_neg_q  <= dv_side.neg;
    m1_bad_q  <= dv_side.bad;
    m1_tag_q  <= dv_side.tag;
    m2_s_q    <= m2_s_d;
    m2_ssq_q  <= m2_ssq_d;
    m2_bad_q  <= m1_bad_q;
    m2_tag_q  <= m1_tag_q;
    m3_um_q   <= m3_uf_d[RATIO_BITS-1:0];
    m3_neg_q  <= m3_neg_d;
    m3_bad_q  <= m3_bad_d;
    m3_ssq_q  <= m2_ssq_q;
    m3_tag_q  <= m2_tag_q;
    m4_usq_q  <= m4_usq_d;
    m4_um_q   <= m3_um_q;
    m4_neg_q  <= m3_neg_q;
    m4_bad_q  <= m3_bad_q;
    m4_ssq_q  <= m3_ssq_q;
    m4_tag_q  <= m3_tag_q;
    m5_rad_q  <= m5_vsq_d[VSQ_W-1:0];
    m5_side_q <= m5_side_d;
  end

  fssr_sqrt u_sqrt (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_vld_i  (m5_vld_q),
    .rad_i     (m5_rad_q),
    .side_i    (m5_side_q),
    .out_vld_o (sq_vld),
    .root_o    (sq_root),
    .side_o    (sq_side)
  );

  fssr_wgt #(
    .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
  ) u_wgt (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_vld_i     (sq_vld),
    .root_i       (sq_root),
    .side_i       (sq_side),
    .done_o       (done_o),
    .weight_o     (weight_o),
    .in_support_o (in_support_o),
    .tag_out_o    (tag_out_o)
  );

endmodule

FILE: bench/testbench.sv
// Self-checking bench for the pipelined sample weight unit: predicted and observed words.
`timescale 1ns / 100ps

class weight_board;
  localparam int RB = 28;
  localparam longint unsigned ONE = 64'd1 << RB;
  typedef struct {
    logic [16:0] weight;
    logic        support;
    logic [31:0] tag;
  } weight_t;
  weight_t pending[$];
  int unsigned mismatches;
  int unsigned checked;
  int unsigned in_count;

  function automatic longint unsigned root(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned falloff(longint unsigned w, longint unsigned wsq);
    longint unsigned t;
    t = (wsq * (3 * ONE - 2 * w)) >> RB;
    return (t >= ONE) ? 0 : ONE - t;
  endfunction

  function void note(logic signed [31:0] p[3], logic signed [31:0] c[3],
                     logic signed [15:0] n[3], logic [30:0] fp, logic [31:0] tag);
    weight_t e;
    longint unsigned range, mag, r, sumsq, usq, vsq, ax, tg, w, v;
    longint q[3];
    longint d, s, u;
    bit ok;
    e.tag = tag;
    e.weight = 0;
    e.support = 0;
    range = 3 * longint'(fp);
    ok = (range != 0);
    sumsq = 0;
    s = 0;
    for (int i = 0; i < 3 && ok; i++) begin
      d = longint'(p[i]) - longint'(c[i]);
      mag = (d < 0) ? -d : d;
      if (mag >= 2 * range) ok = 0;
      else begin
        r = (mag << RB) / range;
        q[i] = (d < 0) ? -longint'(r) : longint'(r);
      end
    end
    if (ok) begin
      for (int i = 0; i < 3; i++) begin
        s += longint'(n[i]) * q[i];
        sumsq += q[i] * q[i];
      end
      u = s / 16384;
      if (u <= -longint'(ONE) || u >= longint'(ONE)) ok = 0;
      if (ok) begin
        usq = u * u;
        vsq = (sumsq > usq) ? sumsq - usq : 0;
        if (vsq >= ONE * ONE) ok = 0;
        if (ok) begin
          v = root(vsq);
          if (u < 0) begin
            w = ONE - longint'(-u);
            ax = (w * w) >> RB;
          end else begin
            ax = falloff(u, usq >> RB);
          end
          tg = falloff(v, vsq >> RB);
          w = (ax * tg) >> (2 * RB - 16);
          if (w > 65536) w = 65536;
          e.weight = w[16:0];
          e.support = 1;
        end
      end
    end
    pending.push_back(e);
  endfunction

  function void check(logic [16:0] weight, logic support, logic [31:0] tag);
    weight_t e;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected word: weight %0d tag %h", weight, tag);
      return;
    end
    e = pending.pop_front();
    checked++;
    if (support) in_count++;
    if (e.weight !== weight || e.support !== support || e.tag !== tag) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: exp w %0d s %0b tag %h, got w %0d s %0b tag %h",
                 e.weight, e.support, e.tag, weight, support, tag);
    end
  endfunction
endclass

module testbench;
  import fssr_pkg::*;

  logic clk = 0;
  logic rst_n = 0;
  logic start = 0;
  logic busy;
  logic signed [COORD_W-1:0] px = 0, py = 0, pz = 0, cx = 0, cy = 0, cz = 0;
  logic signed [NRM_W-1:0] nx = 0, ny = 0, nz = 0;
  logic [FP_W-1:0] fp = 0;
  logic [TAG_W-1:0] tag = 0;
  logic done, in_support;
  logic [16:0] weight;
  logic [TAG_W-1:0] tag_out;
  weight_board board = new();
  int unsigned idle_cycles = 0;
  int unsigned sent = 0;
  bit timed_out = 0;

  always #10 clk = ~clk;

  fssr_sample_weight_unit DUT (
    .clk_i(clk), .rst_ni(rst_n), .start_i(start), .busy_o(busy),
    .point_x_i(px), .point_y_i(py), .point_z_i(pz),
    .center_x_i(cx), .center_y_i(cy), .center_z_i(cz),
    .normal_x_i(nx), .normal_y_i(ny), .normal_z_i(nz),
    .footprint_i(fp), .sample_tag_i(tag),
    .done_o(done), .weight_o(weight), .in_support_o(in_support), .tag_out_o(tag_out)
  );

  always @(posedge clk) begin
    if (rst_n) begin
      if (done) board.check(weight, in_support, tag_out);
      if ((start && !busy) || done) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 5000) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  task automatic send_word(logic signed [31:0] p[3], logic signed [31:0] c[3],
                           logic signed [15:0] n[3], logic [30:0] f);
    px <= p[0]; py <= p[1]; pz <= p[2];
    cx <= c[0]; cy <= c[1]; cz <= c[2];
    nx <= n[0]; ny <= n[1]; nz <= n[2];
    fp <= f;
    tag <= $urandom;
    start <= 1;
    do @(posedge clk); while (busy);
    board.note(p, c, n, f, tag);
    sent++;
  endtask

  task automatic pause();
    int g;
    g = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 60) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) g = 0;
    if (g > 0) begin
      start <= 0;
      repeat (g) @(posedge clk);
    end
  endtask

  function automatic logic signed [15:0] rnd_normal(int mode);
    case (mode)
      0: return 16'sd16384;
      1: return -16'sd16384;
      2: return 16'($urandom_range(0, 32768) - 16384);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_word();
    logic signed [31:0] p[3], c[3];
    logic signed [15:0] n[3];
    logic [30:0] f;
    int k, nm;
    longint span;
    k = $urandom_range(0, 9);
    if (k < 7) begin
      f = (k == 0) ? 31'($urandom) : 31'($urandom_range(1, 1 << $urandom_range(1, 24)));
      span = 3 * longint'(f);
      for (int i = 0; i < 3; i++) begin
        c[i] = $urandom;
        p[i] = 32'(c[i] + longint'($urandom_range(0, 1000)) * span / 1000 *
                   ($urandom_range(0, 1) ? 1 : -1));
      end
    end else begin
      f = 31'($urandom);
      for (int i = 0; i < 3; i++) begin
        p[i] = $urandom;
        c[i] = $urandom;
      end
    end
    if (k == 9) f = 0;
    nm = $urandom_range(0, 3);
    for (int i = 0; i < 3; i++) n[i] = 0;
    if (nm < 2) n[$urandom_range(0, 2)] = rnd_normal(nm);
    else for (int i = 0; i < 3; i++) n[i] = rnd_normal(nm);
    send_word(p, c, n, f);
  endtask

  task automatic directed();
    logic signed [31:0] p[3], c[3];
    logic signed [15:0] n[3];
    n = '{16'sd16384, 16'sd0, 16'sd0};
    c = '{32'sd0, 32'sd0, 32'sd0};
    p = '{32'sd0, 32'sd0, 32'sd0};
    send_word(p, c, n, 31'd65536);
    send_word(p, c, n, 31'd0);
    p = '{-32'sd98304, 32'sd0, 32'sd0};
    send_word(p, c, n, 31'd65536);
    p = '{-32'sd98303, 32'sd0, 32'sd0};
    send_word(p, c, n, 31'd65536);
    p = '{32'sd98303, 32'sd0, 32'sd0};
    send_word(p, c, n, 31'd65536);
    p = '{32'sd98304, 32'sd0, 32'sd0};
    send_word(p, c, n, 31'd65536);
    p = '{32'sd0, 32'sd98303, 32'sd0};
    send_word(p, c, n, 31'd65536);
    p = '{32'sd0, 32'sd0, 32'sd196608};
    send_word(p, c, n, 31'd65536);
    p = '{32'sd40000, 32'sd30000, -32'sd20000};
    send_word(p, c, n, 31'd65536);
    n = '{-16'sd16384, 16'sd0, 16'sd0};
    send_word(p, c, n, 31'd65536);
    n = '{16'sd1000, 16'sd1000, 16'sd1000};
    send_word(p, c, n, 31'd65536);
    n = '{-16'sd32768, 16'sd32767, 16'sd32767};
    send_word(p, c, n, 31'd65536);
    p = '{32'sh7fffffff, 32'sh80000000, 32'sh7fffffff};
    c = '{32'sh80000000, 32'sh7fffffff, 32'sh80000000};
    send_word(p, c, n, 31'h7fffffff);
    p = '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff};
    c = '{32'sh7ffffff0, 32'sh7ffffff0, 32'sh7ffffff0};
    n = '{16'sd0, 16'sd0, 16'sd16384};
    send_word(p, c, n, 31'd1);
    send_word(p, c, n, 31'h7fffffff);
    p = '{32'sd1, 32'sd0, 32'sd0};
    c = '{32'sd0, 32'sd0, 32'sd0};
    send_word(p, c, n, 31'd1);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    directed();
    pause();
    repeat (2000) begin
      random_word();
      pause();
    end
    start <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    $display("%0d words sent, %0d results checked, %0d inside the support",
             sent, board.checked, board.in_count);
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches", board.mismatches);
      $display("simulation failed");
    end
    $finish;
  end
endmodule
